FILE: rtl/patol_pkg.sv
package patol_pkg;

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAFETY   = 3'd4;

    // Safety factor, unsigned Q4.12
    localparam int SF_W    = 16;
    localparam int SF_FRAC = 12;
    localparam logic [SF_W-1:0] SF_RESET = 16'd4096;

    // Result layout in m_tdata
    localparam int TILE_W     = 6;
    localparam int OUT_W      = 8;
    localparam int OVL_BIT    = 6;
    localparam int RN_BIT     = 7;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // Square with saturation at 2^64-1
    function automatic logic [63:0] sat_sq(input logic [63:0] v);
        logic [63:0] p;
        p = {32'b0, v[31:0]} * {32'b0, v[31:0]};
        return (|v[63:32]) ? '1 : p;
    endfunction

    // Add with saturation at 2^64-1
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

endpackage

FILE: rtl/periodic_aabb_tile_overlap.sv
// Periodic bounding-box tile overlap test. Load requests append a local tile
// (box corners and largest kernel radius, unsigned Q16.16) to a tile memory
// of MAX_TILES entries, a clear request empties it, and a query request
// tests one remote tile against every stored tile in index order, giving one
// result per stored tile (one result with no overlap if the table is empty).
// The tile memory is read once per cycle while the result channel is not
// stalled, so a query issues max(tiles, 1) reads and each result passes
// through the compare pipeline into the m_tdata register; the next request
// is taken once the compare pipeline has drained. Clear and load give no
// result. The per-axis test is centre distance, optional periodic wrap,
// minus both half-widths; the squared gaps are summed with 64-bit
// saturation and compared against the squared search radius (max radius
// times the Q4.12 safety factor). Configuration registers must only be
// written while no query is in flight.
module periodic_aabb_tile_overlap #(
    parameter int MAX_TILES  = 64,
    parameter int COORD_BITS = 32,
    localparam int IN_W = ((7 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, radius
    input  logic [IN_W-1:0]                      s_tdata,
    // op
    input  logic [1:0]                           s_tuser,
    // result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // local_tile, overlaps, remote_needed
    output logic [patol_pkg::OUT_W-1:0]          m_tdata,
    output logic                                 m_tlast,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [patol_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [patol_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import patol_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int TW  = 7 * CB;
    localparam int AW  = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int CW  = $clog2(MAX_TILES + 1);
    localparam int RW  = CB + SF_W - SF_FRAC;
    localparam int NST = 8;

    typedef struct packed {
        logic [CW-1:0] idx;
        logic          last;
        logic          nul;
    } meta_t;

    // Configuration registers
    logic [CB-1:0]   box_reg [3];
    logic [2:0]      per_reg;
    logic [SF_W-1:0] sf_reg;

    // Control
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            any_reg, any_next;
    logic [NST-1:0]  vld_reg;
    meta_t           meta_reg [NST];
    meta_t           issue_meta;
    logic            s_acc, adv, issue, do_load;

    // Remote tile, precomputed at request
    logic [CB:0]          qc2_reg [3];
    logic signed [CB+1:0] qw2_reg [3];
    logic [CB-1:0]        qr_reg;

    // Tile memory
    logic [TW-1:0] mem [MAX_TILES];
    logic [TW-1:0] rd_reg;

    // Pipeline stage registers
    logic [CB:0]          a_c2_reg [3];
    logic signed [CB+1:0] a_w2_reg [3];
    logic [CB-1:0]        a_rmax_reg;
    logic signed [CB+1:0] b_diff_reg [3];
    logic signed [CB+2:0] b_wsum_reg [3];
    logic [RW-1:0]        b_r_reg;
    logic [CB:0]          c_d2_reg [3];
    logic signed [CB+2:0] c_wsum_reg [3];
    logic [RW-1:0]        c_r_reg;
    logic [63:0]          c_rsq_reg;
    logic                 c_rz_reg;
    logic signed [CB+2:0] d_d2w_reg [3];
    logic signed [CB+2:0] d_wsum_reg [3];
    logic [RW-1:0]        d_r_reg;
    logic [63:0]          d_rsq_reg;
    logic                 d_rz_reg;
    logic [2:0]           e_pos_reg;
    logic [CB+2:0]        e_gap_reg [3];
    logic [RW-1:0]        e_r_reg;
    logic [63:0]          e_rsq_reg;
    logic                 e_rz_reg;
    logic [2:0]           f_far_reg;
    logic [63:0]          f_sq_reg [3];
    logic [63:0]          f_rsq_reg;
    logic                 f_rz_reg;
    logic [63:0]          g_s01_reg;
    logic [63:0]          g_sq2_reg;
    logic                 g_far_reg;
    logic [63:0]          g_rsq_reg;
    logic                 g_rz_reg;

    // Result register
    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg;
    logic                 m_tlast_reg;

    // Stage combinational values
    logic [CB:0]          a_c2 [3];
    logic signed [CB+1:0] a_w2 [3];
    logic [CB+SF_W-1:0]   b_prod;
    logic signed [CB+1:0] b_diff [3];
    logic signed [CB+2:0] b_wsum [3];
    logic signed [CB+1:0] c_neg [3];
    logic [CB:0]          c_d2 [3];
    logic signed [CB+2:0] d_d2w [3];
    logic signed [CB+3:0] e_g2 [3];
    logic [2:0]           f_far;
    logic [63:0]          f_sq [3];
    logic [63:0]          o_sum;
    logic                 o_hit;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && !(|vld_reg);
    assign s_acc     = s_tvalid && s_tready;
    assign adv       = !m_tvalid_reg || m_tready;
    assign issue     = (state_reg == ST_RUN) && adv;
    assign do_load   = s_acc && (op_t'(s_tuser) == OP_LOAD) && (count_reg < CW'(MAX_TILES));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Issue tag for the next tile read
    always_comb
    begin
        issue_meta.idx  = idx_reg;
        issue_meta.nul  = (count_reg == '0);
        issue_meta.last = (count_reg == '0) || ((idx_reg + CW'(1)) == count_reg);
    end

    // Request sequencing
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    case (op_t'(s_tuser))
                        OP_CLEAR: count_next = '0;
                        OP_LOAD:
                        begin
                            if (do_load)
                                count_next = count_reg + CW'(1);
                        end
                        OP_QUERY:
                        begin
                            idx_next   = '0;
                            state_next = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    if (issue_meta.last)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg + CW'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg[0] <= '0;
            box_reg[1] <= '0;
            box_reg[2] <= '0;
            per_reg    <= '0;
            sf_reg     <= SF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BOX_X:    box_reg[0] <= cfg_data[CB-1:0];
                REG_BOX_Y:    box_reg[1] <= cfg_data[CB-1:0];
                REG_BOX_Z:    box_reg[2] <= cfg_data[CB-1:0];
                REG_PERIODIC: per_reg    <= cfg_data[2:0];
                REG_SAFETY:   sf_reg     <= cfg_data[SF_W-1:0];
                default: ;
            endcase
        end
    end

    // Remote tile centre and half-width in half-LSB units
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                qc2_reg[k] <= {1'b0, s_tdata[k*CB +: CB]} + {1'b0, s_tdata[(k+3)*CB +: CB]};
                qw2_reg[k] <= signed'({2'b00, s_tdata[(k+3)*CB +: CB]})
                            - signed'({2'b00, s_tdata[k*CB +: CB]});
            end
            qr_reg <= s_tdata[6*CB +: CB];
        end
    end

    // Tile memory: append on load, one read per issued tile
    always_ff @(posedge clk)
    begin
        if (do_load)
            mem[count_reg[AW-1:0]] <= s_tdata[TW-1:0];
        if (issue)
            rd_reg <= mem[idx_reg[AW-1:0]];
    end

    // Valid and tag pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], issue};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0] <= issue_meta;
            for (int s = 1; s < NST; s++)
                meta_reg[s] <= meta_reg[s-1];
        end
    end

    // Stage datapath
    always_comb
    begin
        b_prod = (CB+SF_W)'(a_rmax_reg) * (CB+SF_W)'(sf_reg);
        for (int k = 0; k < 3; k++)
        begin
            // centre and width of the stored tile
            a_c2[k] = {1'b0, rd_reg[k*CB +: CB]} + {1'b0, rd_reg[(k+3)*CB +: CB]};
            a_w2[k] = signed'({2'b00, rd_reg[(k+3)*CB +: CB]})
                    - signed'({2'b00, rd_reg[k*CB +: CB]});
            // centre distance and combined width
            b_diff[k] = signed'({1'b0, a_c2_reg[k]}) - signed'({1'b0, qc2_reg[k]});
            b_wsum[k] = (CB+3)'(a_w2_reg[k]) + (CB+3)'(qw2_reg[k]);
            // magnitude
            c_neg[k] = -b_diff_reg[k];
            c_d2[k]  = b_diff_reg[k][CB+1] ? c_neg[k][CB:0] : b_diff_reg[k][CB:0];
            // periodic wrap
            if (per_reg[k] && (c_d2_reg[k] > {1'b0, box_reg[k]}))
                d_d2w[k] = signed'({2'b00, box_reg[k], 1'b0}) - signed'({2'b00, c_d2_reg[k]});
            else
                d_d2w[k] = signed'({2'b00, c_d2_reg[k]});
            // doubled gap
            e_g2[k] = (CB+4)'(d_d2w_reg[k]) - (CB+4)'(d_wsum_reg[k]);
            // reject and square
            f_far[k] = e_pos_reg[k] && (64'(e_gap_reg[k]) > 64'(e_r_reg));
            f_sq[k]  = e_pos_reg[k] ? sat_sq(64'(e_gap_reg[k])) : '0;
        end
        o_sum = sat_add(g_s01_reg, g_sq2_reg);
        o_hit = !meta_reg[NST-1].nul && !g_rz_reg && !g_far_reg && (o_sum < g_rsq_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_c2_reg[k]   <= a_c2[k];
                a_w2_reg[k]   <= a_w2[k];
                b_diff_reg[k] <= b_diff[k];
                b_wsum_reg[k] <= b_wsum[k];
                c_d2_reg[k]   <= c_d2[k];
                c_wsum_reg[k] <= b_wsum_reg[k];
                d_d2w_reg[k]  <= d_d2w[k];
                d_wsum_reg[k] <= c_wsum_reg[k];
                e_pos_reg[k]  <= !e_g2[k][CB+3] && (|e_g2[k]);
                e_gap_reg[k]  <= e_g2[k][CB+3:1];
                f_sq_reg[k]   <= f_sq[k];
            end
            a_rmax_reg <= (rd_reg[6*CB +: CB] > qr_reg) ? rd_reg[6*CB +: CB] : qr_reg;
            b_r_reg    <= b_prod[CB+SF_W-1:SF_FRAC];
            c_r_reg    <= b_r_reg;
            c_rsq_reg  <= sat_sq(64'(b_r_reg));
            c_rz_reg   <= (b_r_reg == '0);
            d_r_reg    <= c_r_reg;
            d_rsq_reg  <= c_rsq_reg;
            d_rz_reg   <= c_rz_reg;
            e_r_reg    <= d_r_reg;
            e_rsq_reg  <= d_rsq_reg;
            e_rz_reg   <= d_rz_reg;
            f_far_reg  <= f_far;
            f_rsq_reg  <= e_rsq_reg;
            f_rz_reg   <= e_rz_reg;
            g_s01_reg  <= sat_add(f_sq_reg[0], f_sq_reg[1]);
            g_sq2_reg  <= f_sq_reg[2];
            g_far_reg  <= |f_far_reg;
            g_rsq_reg  <= f_rsq_reg;
            g_rz_reg   <= f_rz_reg;
        end
    end

    // Overlap-seen flag across one query
    always_comb
    begin
        any_next = any_reg;
        if (adv && vld_reg[NST-1])
            any_next = meta_reg[NST-1].last ? 1'b0 : (any_reg || o_hit);
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            any_reg      <= 1'b0;
        end
        else
        begin
            any_reg <= any_next;
            if (adv)
                m_tvalid_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[NST-1])
        begin
            m_tdata_reg[TILE_W-1:0] <= TILE_W'(meta_reg[NST-1].idx);
            m_tdata_reg[OVL_BIT]    <= o_hit;
            m_tdata_reg[RN_BIT]     <= meta_reg[NST-1].last && (any_reg || o_hit);
            m_tlast_reg             <= meta_reg[NST-1].last;
        end
    end

endmodule

FILE: rtl/patol_checker.sv
module patol_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [1:0]                   s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [patol_pkg::OUT_W-1:0]  m_tdata,
    input logic                         m_tlast
);
    import patol_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // The overlap summary appears only on the final result of a query
    a_rn_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[RN_BIT] |-> m_tlast)
        else $error("remote_needed set on a non-final result");

    // No new request while a query still has results to come
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken in the middle of a query");

    // An accepted query blocks the request channel on the next cycle
    a_query: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_QUERY) |=> !s_tready)
        else $error("request channel open right after a query");

endmodule

bind periodic_aabb_tile_overlap patol_checker u_patol_checker (.*);
